>>> src/mcmp_pkg.sv
// ----------------------------------------------------------------------------
// mcmp_pkg
// Shared types and constants of the MIDI channel message parser: byte codes,
// status nibbles, event kinds, register indexes and the parser state record.
// ----------------------------------------------------------------------------
`default_nettype none

package mcmp_pkg;

    // System bytes
    localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
    localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
    localparam logic [7:0] BYTE_NO_STATUS   = 8'h00;

    // Voice status nibbles
    localparam logic [3:0] NIB_NOTE_OFF         = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON          = 4'h9;
    localparam logic [3:0] NIB_CONTROL_CHANGE   = 4'hB;
    localparam logic [3:0] NIB_PROGRAM_CHANGE   = 4'hC;
    localparam logic [3:0] NIB_CHANNEL_PRESSURE = 4'hD;
    localparam logic [3:0] NIB_PITCH_BEND       = 4'hE;

    // Data phase codes
    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_FIRST  = 2'd1;
    localparam logic [1:0] PHASE_SECOND = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LISTEN_CHANNEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OMNI_MODE      = 1'b1;

    typedef enum logic [2:0] {
        EV_NOTE_ON        = 3'd0,
        EV_NOTE_OFF       = 3'd1,
        EV_CONTROL_CHANGE = 3'd2,
        EV_PITCH_BEND     = 3'd3,
        EV_PROGRAM_CHANGE = 3'd4,
        EV_SYSEX_START    = 3'd5,
        EV_SYSEX_DATA     = 3'd6,
        EV_SYSEX_END      = 3'd7
    } event_kind_t;

    typedef struct packed {
        logic [7:0] running_status;
        logic [1:0] data_phase;
        logic [6:0] held_first_data;
        logic       in_sysex;
    } parse_state_t;

    typedef struct packed {
        event_kind_t kind;
        logic [3:0]  channel;
        logic [6:0]  first;
        logic [6:0]  second;
    } midi_event_t;

endpackage

`default_nettype wire

>>> src/midi_channel_message_parser_unit.sv
// ----------------------------------------------------------------------------
// midi_channel_message_parser_unit
// Running-status MIDI parser: one byte in, at most one decoded event out.
// Input reg, then result reg; the parse step is a single shallow pass.
// Throughput: one byte per cycle unless an event byte waits on a held result reg.
// A byte that decodes to no event leaves the pipe without using the result
// register, so it never waits on out_ready.
// Reset (rst_n low, async): pipe empty, no running status, not in sysex,
// listen_channel 0, omni off.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_channel_message_parser_unit
    import mcmp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // configuration write port
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    // byte input channel
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             midi_byte,

    // event output channel
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [2:0]                  event_kind,
    output logic [3:0]                  channel_number,
    output logic [6:0]                  first_value,
    output logic [6:0]                  second_value
);

    // configuration registers
    logic [3:0]   listen_channel_reg;
    logic         omni_mode_reg;

    // input stage
    logic         byte_valid_reg;
    logic [7:0]   byte_reg;

    // parser state
    parse_state_t state_reg;
    parse_state_t state_next;

    // result stage
    logic         out_valid_reg;
    midi_event_t  event_reg;

    logic         step_emit;
    midi_event_t  step_event;
    logic         advance;
    logic         out_free;

    // Configuration: the user writes only while the pipe is idle (unchecked).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listen_channel_reg <= 4'd0;
            omni_mode_reg      <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_LISTEN_CHANNEL: listen_channel_reg <= cfg_data;
                CFG_OMNI_MODE:      omni_mode_reg      <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    mcmp_step u_step (
        .midi_byte      (byte_reg),
        .cur_state      (state_reg),
        .listen_channel (listen_channel_reg),
        .omni_mode      (omni_mode_reg),
        .next_state     (state_next),
        .emit           (step_emit),
        .event_out      (step_event)
    );

    // The result slot is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || out_ready;
    // Advance the held byte unless it has an event and the slot is busy.
    assign advance  = byte_valid_reg && (!step_emit || out_free);
    assign in_ready = !byte_valid_reg || advance;

    // Input register: capture a new beat whenever the stage frees up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_valid_reg <= 1'b0;
        else if (in_ready)
            byte_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= midi_byte;
    end

    // Parser state: commit only when the byte actually leaves the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.running_status  <= BYTE_NO_STATUS;
            state_reg.data_phase      <= PHASE_IDLE;
            state_reg.held_first_data <= 7'd0;
            state_reg.in_sysex        <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: load on an emitting advance, drop when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && step_emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_emit)
            event_reg <= step_event;
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = event_reg.kind;
    assign channel_number = event_reg.channel;
    assign first_value    = event_reg.first;
    assign second_value   = event_reg.second;

endmodule

`default_nettype wire

>>> src/mcmp_step.sv
// ----------------------------------------------------------------------------
// mcmp_step
// Single-byte parse step: classifies one byte against the current parser
// state and yields the next state and at most one decoded event.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmp_step
    import mcmp_pkg::*;
(
    input  wire logic [7:0]   midi_byte,
    input  wire parse_state_t cur_state,
    input  wire logic [3:0]   listen_channel,
    input  wire logic         omni_mode,
    output parse_state_t      next_state,
    output logic              emit,
    output midi_event_t       event_out
);

    logic [3:0] status_nib;
    logic [3:0] status_ch;
    logic       chan_ok;

    assign status_nib = cur_state.running_status[7:4];
    assign status_ch  = cur_state.running_status[3:0];
    assign chan_ok    = (status_ch == listen_channel) || omni_mode;

    always_comb
    begin
        next_state = cur_state;
        emit       = 1'b0;
        event_out  = '{kind: EV_SYSEX_DATA, channel: 4'd0, first: 7'd0, second: 7'd0};

        priority if (midi_byte > BYTE_SYSEX_END)
        begin
            // realtime: drop
        end
        else if (midi_byte >= BYTE_SYSEX_START)
        begin
            next_state.running_status = BYTE_NO_STATUS;
            next_state.data_phase     = PHASE_IDLE;
            if (midi_byte == BYTE_SYSEX_START)
            begin
                next_state.in_sysex = 1'b1;
                emit                = 1'b1;
                event_out.kind      = EV_SYSEX_START;
            end
            else if (midi_byte == BYTE_SYSEX_END && cur_state.in_sysex)
            begin
                next_state.in_sysex = 1'b0;
                emit                = 1'b1;
                event_out.kind      = EV_SYSEX_END;
            end
        end
        else if (cur_state.in_sysex)
        begin
            emit            = 1'b1;
            event_out.kind  = EV_SYSEX_DATA;
            event_out.first = midi_byte[6:0];
        end
        else if (midi_byte[7])
        begin
            next_state.running_status = midi_byte;
            next_state.data_phase     = PHASE_FIRST;
        end
        else if (cur_state.running_status == BYTE_NO_STATUS)
        begin
            // stray data byte: drop
        end
        else if (cur_state.data_phase != PHASE_SECOND)
        begin
            if (status_nib == NIB_PROGRAM_CHANGE || status_nib == NIB_CHANNEL_PRESSURE)
            begin
                next_state.data_phase = PHASE_FIRST;
                if (status_nib == NIB_PROGRAM_CHANGE && chan_ok)
                begin
                    emit              = 1'b1;
                    event_out.kind    = EV_PROGRAM_CHANGE;
                    event_out.channel = status_ch;
                    event_out.first   = midi_byte[6:0];
                end
            end
            else
            begin
                next_state.held_first_data = midi_byte[6:0];
                next_state.data_phase      = PHASE_SECOND;
            end
        end
        else
        begin
            next_state.data_phase = PHASE_FIRST;
            event_out.channel     = status_ch;
            event_out.first       = cur_state.held_first_data;
            event_out.second      = midi_byte[6:0];
            if (chan_ok)
            begin
                unique case (status_nib)
                    NIB_NOTE_ON:
                    begin
                        emit = 1'b1;
                        if (midi_byte[6:0] != 7'd0)
                            event_out.kind = EV_NOTE_ON;
                        else
                            event_out.kind = EV_NOTE_OFF;
                    end
                    NIB_NOTE_OFF:
                    begin
                        emit           = 1'b1;
                        event_out.kind = EV_NOTE_OFF;
                    end
                    NIB_CONTROL_CHANGE:
                    begin
                        emit           = 1'b1;
                        event_out.kind = EV_CONTROL_CHANGE;
                    end
                    NIB_PITCH_BEND:
                    begin
                        emit           = 1'b1;
                        event_out.kind = EV_PITCH_BEND;
                    end
                    default:
                    begin
                        // poly pressure: consume
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> bench/midi_channel_message_parser_unit_test.sv
// ----------------------------------------------------------------------------
// midi_channel_message_parser_unit_test
// Self-checking bench for the running-status MIDI parser. A behavioral
// parser inside the bench tracks running status, data phase and sysex mode,
// and queues the event each accepted byte should produce. Directed byte
// streams cover the message types and corner cases. Random message streams
// with random idles on both channels follow, across several channel settings.
// ----------------------------------------------------------------------------

module midi_channel_message_parser_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mcmp_pkg::*;

    // Bytes the package has no name for
    localparam logic [3:0] NIB_POLY_PRESSURE  = 4'hA;
    localparam logic [7:0] BYTE_TIMING_CLOCK  = 8'hF8;
    localparam logic [7:0] BYTE_SYSTEM_RESET  = 8'hFF;
    localparam logic [7:0] BYTE_TIME_CODE     = 8'hF1;
    localparam logic [7:0] BYTE_SONG_SELECT   = 8'hF3;
    localparam logic [7:0] BYTE_TUNE_REQUEST  = 8'hF6;

    // Cycles to let the two-stage pipe empty of bytes that make no event
    localparam int PIPE_SETTLE    = 4;
    localparam int IDLE_PCT       = 32;
    localparam int RANDOM_BYTES   = 900;
    localparam int MAX_PRINTS     = 50;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic [7:0]             midi_byte    = 8'h00;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [2:0]             event_kind;
    logic [3:0]             channel_number;
    logic [6:0]             first_value;
    logic [6:0]             second_value;

    midi_channel_message_parser_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .midi_byte      (midi_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_kind     (event_kind),
        .channel_number (channel_number),
        .first_value    (first_value),
        .second_value   (second_value)
    );

    always #1ns clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state: mirror of the parser, its settings and the event queue
    // ------------------------------------------------------------------------
    logic [7:0]  run_status  = BYTE_NO_STATUS;
    logic [1:0]  phase       = PHASE_IDLE;
    logic [6:0]  held_data   = '0;
    logic        sysex_open  = 1'b0;
    logic [3:0]  listen_ch   = 4'd0;
    logic        omni_on     = 1'b0;

    midi_event_t pending_events [$];

    int idle_pct        = IDLE_PCT;   // sender idles in this share of cycles
    int stall_pct       = IDLE_PCT;   // receiver stalls in this share
    int bytes_counted   = 0;          // accepted bytes that are not realtime
    int mismatch_count  = 0;

    // ------------------------------------------------------------------------
    // Mismatch reporting: one line per problem, printing capped
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void queue_event(input event_kind_t kind, input logic [3:0] chan,
                                        input logic [6:0] first, input logic [6:0] second);
        midi_event_t ev;
        ev.kind    = kind;
        ev.channel = chan;
        ev.first   = first;
        ev.second  = second;
        pending_events.push_back(ev);
    endfunction

    // ------------------------------------------------------------------------
    // Parser mirror: advance the state for one accepted byte and queue the
    // event it should produce, if any.
    // ------------------------------------------------------------------------
    function automatic void predict_parse(input logic [7:0] b);
        logic [3:0] nib;
        logic [3:0] chan;
        logic       take;

        // Realtime bytes pass through untouched
        if (b > BYTE_SYSEX_END)
            return;

        // System common: drop running status; start/end steer sysex mode
        if (b >= BYTE_SYSEX_START) begin
            run_status = BYTE_NO_STATUS;
            phase      = PHASE_IDLE;
            if (b == BYTE_SYSEX_START) begin
                sysex_open = 1'b1;
                queue_event(EV_SYSEX_START, 4'd0, 7'd0, 7'd0);
            end
            else if (b == BYTE_SYSEX_END && sysex_open) begin
                sysex_open = 1'b0;
                queue_event(EV_SYSEX_END, 4'd0, 7'd0, 7'd0);
            end
            return;
        end

        // Inside sysex even voice status bytes are payload
        if (sysex_open) begin
            queue_event(EV_SYSEX_DATA, 4'd0, b[6:0], 7'd0);
            return;
        end

        if (b[7]) begin
            run_status = b;
            phase      = PHASE_FIRST;
            return;
        end

        if (run_status == BYTE_NO_STATUS)
            return;

        nib  = run_status[7:4];
        chan = run_status[3:0];
        take = (chan == listen_ch) || omni_on;

        if (phase != PHASE_SECOND) begin
            // One-data-byte messages complete here
            if (nib == NIB_PROGRAM_CHANGE || nib == NIB_CHANNEL_PRESSURE) begin
                phase = PHASE_FIRST;
                if (nib == NIB_PROGRAM_CHANGE && take)
                    queue_event(EV_PROGRAM_CHANGE, chan, b[6:0], 7'd0);
                return;
            end
            held_data = b[6:0];
            phase     = PHASE_SECOND;
            return;
        end

        phase = PHASE_FIRST;
        if (!take)
            return;
        case (nib)
            NIB_NOTE_ON:
                if (b != 8'd0)
                    queue_event(EV_NOTE_ON, chan, held_data, b[6:0]);
                else
                    queue_event(EV_NOTE_OFF, chan, held_data, 7'd0);
            NIB_NOTE_OFF:       queue_event(EV_NOTE_OFF, chan, held_data, b[6:0]);
            NIB_CONTROL_CHANGE: queue_event(EV_CONTROL_CHANGE, chan, held_data, b[6:0]);
            NIB_PITCH_BEND:     queue_event(EV_PITCH_BEND, chan, held_data, b[6:0]);
            default: ;          // poly pressure: consumed silently
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Byte sender. Inputs change only at rising edges through nonblocking
    // assignments; ready is read right after the edge, so it is the value
    // the DUT saw at that edge. Valid is never lowered at the accepting edge,
    // so back-to-back beats keep it high without a second assignment.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        midi_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_parse(b);
        if (b <= BYTE_SYSEX_END)
            bytes_counted++;
    endtask

    // Hold the input channel until every queued event has come out, then let
    // trailing no-event bytes leave the pipe.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // Register write; call only after wait_idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == CFG_LISTEN_CHANNEL)
            listen_ch = value[3:0];
        else if (idx == CFG_OMNI_MODE)
            omni_on = value[0];
        @(posedge clk);
    endtask

    task automatic set_channel_mode(input logic [3:0] chan, input logic omni);
        wait_idle();
        write_reg(CFG_LISTEN_CHANNEL, CFG_DATA_W'(chan));
        write_reg(CFG_OMNI_MODE, CFG_DATA_W'(omni));
    endtask

    // ------------------------------------------------------------------------
    // Random content helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] random_data();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    // Drop a realtime byte into the stream now and then, mid-message too.
    task automatic maybe_realtime();
        if ($urandom_range(0, 19) == 0)
            send_byte(8'($urandom_range(BYTE_TIMING_CLOCK, BYTE_SYSTEM_RESET)));
    endtask

    // Well-formed voice message, sometimes under running status, sometimes
    // repeated with fresh data bytes. Half aim at the listen channel.
    task automatic send_voice_message();
        logic [3:0] nib;
        logic [3:0] chan;
        int         n_data;
        case ($urandom_range(0, 6))
            0:       nib = NIB_NOTE_OFF;
            1:       nib = NIB_NOTE_ON;
            2:       nib = NIB_POLY_PRESSURE;
            3:       nib = NIB_CONTROL_CHANGE;
            4:       nib = NIB_PROGRAM_CHANGE;
            5:       nib = NIB_CHANNEL_PRESSURE;
            default: nib = NIB_PITCH_BEND;
        endcase
        chan   = $urandom_range(0, 1) ? listen_ch : 4'($urandom_range(0, 15));
        n_data = (nib == NIB_PROGRAM_CHANGE || nib == NIB_CHANNEL_PRESSURE) ? 1 : 2;
        if ($urandom_range(0, 99) < 80)
            send_byte({nib, chan});
        repeat ($urandom_range(1, 3)) begin
            for (int i = 0; i < n_data; i++) begin
                maybe_realtime();
                send_byte(random_data());
            end
        end
    endtask

    task automatic send_sysex_packet();
        send_byte(BYTE_SYSEX_START);
        repeat ($urandom_range(0, 6)) begin
            maybe_realtime();
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(8'h80, 8'hEF)));
            else
                send_byte(random_data());
        end
        if ($urandom_range(0, 99) < 80)
            send_byte(BYTE_SYSEX_END);
    endtask

    // Mostly well-formed traffic; the rest is broken messages and noise.
    task automatic send_random_message();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            send_voice_message();
        else if (pick < 78)
            send_sysex_packet();
        else if (pick < 88) begin
            // truncated two-byte message, cut off by whatever comes next
            send_byte({$urandom_range(0, 1) ? NIB_NOTE_ON : NIB_CONTROL_CHANGE,
                       $urandom_range(0, 1) ? listen_ch : 4'($urandom_range(0, 15))});
            send_byte(random_data());
        end
        else if (pick < 94)
            send_byte(8'($urandom_range(BYTE_TIME_CODE, BYTE_TUNE_REQUEST)));
        else
            send_byte(8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Voice messages on channel 0 with reset settings (listen 0, omni off).
    task automatic test_voice_messages();
        send_byte(8'h45);                               // data with no status: drop
        send_byte({NIB_NOTE_ON, 4'd0}); send_byte(8'h00); send_byte(8'h7F);
        send_byte(BYTE_TIMING_CLOCK);                   // realtime inside a message
        send_byte(8'h7F); send_byte(8'h00);             // running status, velocity 0
        send_byte({NIB_NOTE_OFF, 4'd0}); send_byte(8'h3C); send_byte(8'h40);
        send_byte({NIB_CONTROL_CHANGE, 4'd0}); send_byte(8'h07); send_byte(8'h64);
        send_byte({NIB_PITCH_BEND, 4'd0}); send_byte(8'h00); send_byte(8'h7F);
        send_byte({NIB_PROGRAM_CHANGE, 4'd0}); send_byte(8'h05); send_byte(8'h7F);
        send_byte({NIB_CHANNEL_PRESSURE, 4'd0}); send_byte(8'h33);
        send_byte({NIB_POLY_PRESSURE, 4'd0}); send_byte(8'h40); send_byte(8'h20);
        // other channel is filtered, running status survives it
        send_byte({NIB_NOTE_ON, 4'd1}); send_byte(8'h3C); send_byte(8'h40);
        send_byte(8'h3C); send_byte(8'h41);
        send_byte(BYTE_SYSTEM_RESET);
    endtask

    // Sysex framing and system common bytes.
    task automatic test_system_bytes();
        send_byte(BYTE_SYSEX_START); send_byte(8'h01); send_byte(8'h7F);
        send_byte({NIB_NOTE_ON, 4'd0});                 // status inside sysex is payload
        send_byte(BYTE_TIMING_CLOCK);
        send_byte(BYTE_SYSEX_START);                    // restart while open
        send_byte(8'h22);
        send_byte(BYTE_SONG_SELECT);                    // system common keeps sysex open
        send_byte(8'h05);
        send_byte(BYTE_SYSEX_END);
        send_byte(BYTE_SYSEX_END);                      // end with nothing open
        send_byte({NIB_NOTE_ON, 4'd0}); send_byte(8'h40);
        send_byte(BYTE_TIME_CODE);                      // clears running status
        send_byte(8'h40); send_byte(8'h40);
    endtask

    // Channel gating across listen channel and omni extremes.
    task automatic test_channel_filter();
        logic [3:0] chans [4] = '{4'd15, 4'd15, 4'd0, 4'd7};
        logic       omnis [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
        for (int s = 0; s < 4; s++) begin
            set_channel_mode(chans[s], omnis[s]);
            send_byte({NIB_NOTE_ON, 4'd15}); send_byte(8'h3C); send_byte(8'h40);
            send_byte({NIB_CONTROL_CHANGE, 4'd0}); send_byte(8'h01); send_byte(8'h02);
            repeat (30) send_random_message();
        end
    endtask

    // Long random stream; reconfigure now and then after a full drain.
    task automatic test_random_stream();
        int stop_at;
        int next_cfg;
        stop_at  = bytes_counted + RANDOM_BYTES;
        next_cfg = bytes_counted + 500;
        while (bytes_counted < stop_at) begin
            send_random_message();
            if (bytes_counted >= next_cfg) begin
                set_channel_mode(4'($urandom_range(0, 15)), $urandom_range(0, 99) < 30);
                next_cfg = bytes_counted + 500;
            end
        end
    endtask

    // Stretch with no idling on either side.
    task automatic test_back_to_back();
        wait_idle();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (150) send_random_message();
        wait_idle();
        idle_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, then compare every output beat with the oldest
    // queued event. Values are read right after the edge, i.e. as the DUT
    // saw them at that edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk) begin
        midi_event_t want;
        if (rst_n) begin
            if ($isunknown(out_valid))
                report_mismatch("out_valid unknown", 0, 0);
            else if (out_valid && out_ready) begin
                if (pending_events.size() == 0)
                    report_mismatch("unexpected event, kind", event_kind, 0);
                else begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind)
                        report_mismatch("event_kind", event_kind, want.kind);
                    if (channel_number !== want.channel)
                        report_mismatch("channel_number", channel_number, want.channel);
                    if (first_value !== want.first)
                        report_mismatch("first_value", first_value, want.first);
                    if (second_value !== want.second)
                        report_mismatch("second_value", second_value, want.second);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_voice_messages();
        test_system_bytes();
        test_channel_filter();
        test_random_stream();
        test_back_to_back();

        // drain, then catch any stray event during the settle cycles
        wait_idle();
        repeat (PIPE_SETTLE) @(posedge clk);

        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial begin
        #1ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
